// File: src/cae_pkg.sv
`timescale 1ns / 1ps

package cae_pkg;

  // Key codes carried by each request.
  localparam logic [2:0] KEY_NONE = 3'd0;
  localparam logic [2:0] KEY_MODE = 3'd1;
  localparam logic [2:0] KEY_NEXT = 3'd2;
  localparam logic [2:0] KEY_INC  = 3'd3;
  localparam logic [2:0] KEY_DEC  = 3'd4;

  // Panel modes.
  localparam logic [1:0] MODE_SHOW  = 2'd0;
  localparam logic [1:0] MODE_TIME  = 2'd1;
  localparam logic [1:0] MODE_ALARM = 2'd2;

  // Field select codes; alarm mode reuses the hour/minute/second order from zero.
  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;

  localparam logic [2:0] ALM_HOUR   = 3'd0;
  localparam logic [2:0] ALM_MINUTE = 3'd1;
  localparam logic [2:0] ALM_SECOND = 3'd2;

  // Field limits.
  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [4:0] FEB_LEAP   = 5'd29;
  localparam logic [4:0] FEB_PLAIN  = 5'd28;
  localparam logic [4:0] DAYS_LONG  = 5'd31;

  // Calendar time held by the panel.
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } held_t;

  // Alarm setting.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } alarm_t;

  // Editor state carried between requests.
  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] field_select;
    logic       ring_enable;
    held_t      held;
    alarm_t     alarm;
  } panel_t;

endpackage

// File: src/cae_edit.sv
`timescale 1ns / 1ps

module cae_edit (
  input  logic [2:0]      key,
  input  cae_pkg::held_t  rtc,
  input  cae_pkg::panel_t cur,
  output cae_pkg::panel_t nxt,
  output logic            ring,
  output logic            write_time
);

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Days in a month; February follows the year's low two bits, bad months get 31.
  function automatic logic [4:0] month_max(input logic [6:0] yr, input logic [3:0] mo);
    logic [4:0] res;
    if (mo == 4'd2) begin
      res = (yr[1:0] == 2'b00) ? cae_pkg::FEB_LEAP : cae_pkg::FEB_PLAIN;
    end else if (mo == 4'd0 || mo > cae_pkg::MONTH_MAX) begin
      res = cae_pkg::DAYS_LONG;
    end else begin
      res = MONTH_DAYS[mo - 4'd1];
    end
    return res;
  endfunction

  // Field select step modulo 6.
  function automatic logic [2:0] step_mod6(input logic [2:0] fs);
    logic [2:0] res;
    case (fs)
      3'd0:    res = 3'd1;
      3'd1:    res = 3'd2;
      3'd2:    res = 3'd3;
      3'd3:    res = 3'd4;
      3'd4:    res = 3'd5;
      3'd5:    res = 3'd0;
      3'd6:    res = 3'd1;
      default: res = 3'd2;
    endcase
    return res;
  endfunction

  // Field select step modulo 3.
  function automatic logic [2:0] step_mod3(input logic [2:0] fs);
    logic [2:0] res;
    case (fs)
      3'd0:    res = 3'd1;
      3'd1:    res = 3'd2;
      3'd2:    res = 3'd0;
      3'd3:    res = 3'd1;
      3'd4:    res = 3'd2;
      3'd5:    res = 3'd0;
      3'd6:    res = 3'd1;
      default: res = 3'd2;
    endcase
    return res;
  endfunction

  logic [1:0]     mode_n;
  logic [2:0]     fs_n;
  logic           ren_n;
  cae_pkg::held_t inc_t;
  cae_pkg::held_t dec_t;
  cae_pkg::alarm_t alm_inc;
  cae_pkg::alarm_t alm_dec;
  logic [7:0]     year_w;
  logic [4:0]     month_w;
  logic [5:0]     day_w;
  logic [5:0]     hour_w;
  logic [6:0]     minute_w;
  logic [6:0]     second_w;
  logic [4:0]     mx_inc;
  logic [4:0]     mx_dec;
  logic           s_yr, s_mo, s_dy, s_hr, s_mi, s_se;
  logic           a_hr, a_mi, a_se;

  // Ring looks at the state before this request changes anything.
  assign ring = cur.ring_enable && (cur.held.hour == cur.alarm.hour) &&
                (cur.held.minute == cur.alarm.minute) &&
                (cur.held.second == cur.alarm.second);

  // Mode sequencing on the mode key.
  always_comb begin
    mode_n     = cur.mode;
    fs_n       = cur.field_select;
    ren_n      = cur.ring_enable;
    write_time = 1'b0;
    if (key == cae_pkg::KEY_MODE) begin
      case (cur.mode)
        cae_pkg::MODE_SHOW: begin
          mode_n = cae_pkg::MODE_TIME;
          ren_n  = 1'b0;
        end
        cae_pkg::MODE_TIME: begin
          mode_n     = cae_pkg::MODE_ALARM;
          write_time = 1'b1;
          fs_n       = 3'd0;
        end
        cae_pkg::MODE_ALARM: begin
          mode_n = cae_pkg::MODE_SHOW;
          fs_n   = 3'd0;
          ren_n  = 1'b1;
        end
        default: begin
          mode_n = cur.mode;
        end
      endcase
    end
  end

  // Time field selects.
  assign s_yr = (fs_n == cae_pkg::FLD_YEAR);
  assign s_mo = (fs_n == cae_pkg::FLD_MONTH);
  assign s_dy = (fs_n == cae_pkg::FLD_DAY);
  assign s_hr = (fs_n == cae_pkg::FLD_HOUR);
  assign s_mi = (fs_n == cae_pkg::FLD_MINUTE);
  assign s_se = (fs_n == cae_pkg::FLD_SECOND);

  // Time increment: add to the selected field, then range-check every field.
  always_comb begin
    year_w   = {1'b0, cur.held.year} + {7'd0, s_yr};
    month_w  = {1'b0, cur.held.month} + {4'd0, s_mo};
    day_w    = {1'b0, cur.held.day} + {5'd0, s_dy};
    hour_w   = {1'b0, cur.held.hour} + {5'd0, s_hr};
    minute_w = {1'b0, cur.held.minute} + {6'd0, s_mi};
    second_w = {1'b0, cur.held.second} + {6'd0, s_se};
    inc_t.year   = (year_w > {1'b0, cae_pkg::YEAR_MAX}) ? 7'd0 : year_w[6:0];
    inc_t.month  = (month_w > {1'b0, cae_pkg::MONTH_MAX}) ? 4'd1 : month_w[3:0];
    mx_inc       = month_max(inc_t.year, inc_t.month);
    inc_t.day    = (day_w > {1'b0, mx_inc}) ? 5'd1 : day_w[4:0];
    inc_t.hour   = (hour_w > {1'b0, cae_pkg::HOUR_MAX}) ? 5'd0 : hour_w[4:0];
    inc_t.minute = (minute_w > {1'b0, cae_pkg::MINSEC_MAX}) ? 6'd0 : minute_w[5:0];
    inc_t.second = (second_w > {1'b0, cae_pkg::MINSEC_MAX}) ? 6'd0 : second_w[5:0];
  end

  // Time decrement: underflow wraps to the top, day is also clamped to the month.
  always_comb begin
    dec_t.year = (cur.held.year == 7'd0 && s_yr) ? cae_pkg::YEAR_MAX
                                                 : cur.held.year - {6'd0, s_yr};
    if (cur.held.month == 4'd0 || (cur.held.month == 4'd1 && s_mo)) begin
      dec_t.month = cae_pkg::MONTH_MAX;
    end else begin
      dec_t.month = cur.held.month - {3'd0, s_mo};
    end
    mx_dec = month_max(dec_t.year, dec_t.month);
    if (cur.held.day == 5'd0 || (cur.held.day == 5'd1 && s_dy)) begin
      dec_t.day = mx_dec;
    end else if ((cur.held.day - {4'd0, s_dy}) > mx_dec) begin
      dec_t.day = mx_dec;
    end else begin
      dec_t.day = cur.held.day - {4'd0, s_dy};
    end
    dec_t.hour   = (cur.held.hour == 5'd0 && s_hr) ? cae_pkg::HOUR_MAX
                                                   : cur.held.hour - {4'd0, s_hr};
    dec_t.minute = (cur.held.minute == 6'd0 && s_mi) ? cae_pkg::MINSEC_MAX
                                                     : cur.held.minute - {5'd0, s_mi};
    dec_t.second = (cur.held.second == 6'd0 && s_se) ? cae_pkg::MINSEC_MAX
                                                     : cur.held.second - {5'd0, s_se};
  end

  // Alarm step with wrap on the selected field.
  assign a_hr = (fs_n == cae_pkg::ALM_HOUR);
  assign a_mi = (fs_n == cae_pkg::ALM_MINUTE);
  assign a_se = (fs_n == cae_pkg::ALM_SECOND);

  always_comb begin
    alm_inc = cur.alarm;
    alm_dec = cur.alarm;
    if (a_hr) begin
      alm_inc.hour = (cur.alarm.hour >= cae_pkg::HOUR_MAX) ? 5'd0 : cur.alarm.hour + 5'd1;
      alm_dec.hour = (cur.alarm.hour == 5'd0) ? cae_pkg::HOUR_MAX : cur.alarm.hour - 5'd1;
    end
    if (a_mi) begin
      alm_inc.minute = (cur.alarm.minute >= cae_pkg::MINSEC_MAX) ? 6'd0
                                                                 : cur.alarm.minute + 6'd1;
      alm_dec.minute = (cur.alarm.minute == 6'd0) ? cae_pkg::MINSEC_MAX
                                                  : cur.alarm.minute - 6'd1;
    end
    if (a_se) begin
      alm_inc.second = (cur.alarm.second >= cae_pkg::MINSEC_MAX) ? 6'd0
                                                                 : cur.alarm.second + 6'd1;
      alm_dec.second = (cur.alarm.second == 6'd0) ? cae_pkg::MINSEC_MAX
                                                  : cur.alarm.second - 6'd1;
    end
  end

  // Apply the action of the mode after sequencing.
  always_comb begin
    nxt.mode         = mode_n;
    nxt.field_select = fs_n;
    nxt.ring_enable  = ren_n;
    nxt.held         = cur.held;
    nxt.alarm        = cur.alarm;
    case (mode_n)
      cae_pkg::MODE_SHOW: begin
        nxt.held = rtc;
      end
      cae_pkg::MODE_TIME: begin
        case (key)
          cae_pkg::KEY_NEXT: nxt.field_select = step_mod6(fs_n);
          cae_pkg::KEY_INC:  nxt.held = inc_t;
          cae_pkg::KEY_DEC:  nxt.held = dec_t;
          default:           nxt.held = cur.held;
        endcase
      end
      cae_pkg::MODE_ALARM: begin
        nxt.held = rtc;
        case (key)
          cae_pkg::KEY_NEXT: nxt.field_select = step_mod3(fs_n);
          cae_pkg::KEY_INC:  nxt.alarm = alm_inc;
          cae_pkg::KEY_DEC:  nxt.alarm = alm_dec;
          default:           nxt.alarm = cur.alarm;
        endcase
      end
      default: begin
        nxt.held = cur.held;
      end
    endcase
  end

endmodule

// File: src/clock_alarm_set_editor_unit.sv
`timescale 1ns / 1ps

// Alarm clock time-set and alarm-set editor.
// Each input request is one pass of the panel loop: a key code and the
// current time read from the clock chip. Each request yields exactly one
// result: the panel mode, the held time, the alarm setting, the ring flag
// and the write strobe that asks for the edited time to go to the clock chip.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low.
// The editor state and the result register both load at the edge that
// accepts a request. Throughput is one request per cycle while the receiver
// does not stall; the single result register is the only stage.
// The input is stalled only while a result sits in the result register and
// the receiver stalls it; the result then holds steady until taken, and a
// new request is accepted in the same cycle the old result leaves.
// Reset puts the panel in show mode with ring enabled, field select zero,
// held time year 0, month 1, day 1, 00:00:00, alarm 00:00:00, and no result
// pending.
module clock_alarm_set_editor_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] key,
  input  logic [6:0] rtc_year,
  input  logic [3:0] rtc_month,
  input  logic [4:0] rtc_day,
  input  logic [4:0] rtc_hour,
  input  logic [5:0] rtc_minute,
  input  logic [5:0] rtc_second,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] ui_mode,
  output logic [6:0] out_year,
  output logic [3:0] out_month,
  output logic [4:0] out_day,
  output logic [4:0] out_hour,
  output logic [5:0] out_minute,
  output logic [5:0] out_second,
  output logic [4:0] alarm_hour_out,
  output logic [5:0] alarm_minute_out,
  output logic [5:0] alarm_second_out,
  output logic       ring,
  output logic       write_time
);

  cae_pkg::panel_t panel;
  cae_pkg::panel_t panel_next;
  cae_pkg::held_t  rtc;
  logic            ring_next;
  logic            write_next;
  logic            accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign rtc = '{year: rtc_year, month: rtc_month, day: rtc_day,
                 hour: rtc_hour, minute: rtc_minute, second: rtc_second};

  // Next editor state and result for the request at the input.
  cae_edit u_edit (
    .key        (key),
    .rtc        (rtc),
    .cur        (panel),
    .nxt        (panel_next),
    .ring       (ring_next),
    .write_time (write_next)
  );

  // Editor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      panel.mode         <= cae_pkg::MODE_SHOW;
      panel.field_select <= 3'd0;
      panel.ring_enable  <= 1'b1;
      panel.held         <= '{year: 7'd0, month: 4'd1, day: 5'd1,
                              hour: 5'd0, minute: 6'd0, second: 6'd0};
      panel.alarm        <= '0;
    end else if (accept) begin
      panel <= panel_next;
    end
  end

  // Result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      ui_mode          <= panel_next.mode;
      out_year         <= panel_next.held.year;
      out_month        <= panel_next.held.month;
      out_day          <= panel_next.held.day;
      out_hour         <= panel_next.held.hour;
      out_minute       <= panel_next.held.minute;
      out_second       <= panel_next.held.second;
      alarm_hour_out   <= panel_next.alarm.hour;
      alarm_minute_out <= panel_next.alarm.minute;
      alarm_second_out <= panel_next.alarm.second;
      ring             <= ring_next;
      write_time       <= write_next;
    end
  end

  // Ring is armed exactly in show mode.
  assert property (@(posedge clk) disable iff (rst)
    panel.ring_enable == (panel.mode == cae_pkg::MODE_SHOW))
    else $error("ring enable out of step with panel mode");

  // The write strobe only comes with the step into alarm-set mode.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && write_time |-> ui_mode == cae_pkg::MODE_ALARM)
    else $error("write strobe outside the time-set exit");

  // The result register mirrors the editor state it was loaded with.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> ui_mode == panel.mode && out_hour == panel.held.hour &&
               alarm_second_out == panel.alarm.second)
    else $error("result register disagrees with editor state");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 10;
  localparam int IDLE_PCT = 32;
  localparam int PASS_TOTAL = 1550;
  localparam int STEADY_FROM = 500;
  localparam int STEADY_TO = 700;
  localparam int MID_DRAIN = 900;
  localparam int DRAIN_CYCLES = 6;
  localparam int TIMEOUT_NS = 3_000_000;
  localparam int REPORT_LIMIT = 10;

  // Key codes beyond the defined set; the editor treats them as no key.
  localparam logic [2:0] KEY_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KEY_SPARE_LAST = 3'd7;

  // Limits as plain integers, so that signed comparisons stay signed.
  localparam int YR_TOP = cae_pkg::YEAR_MAX;
  localparam int MO_TOP = cae_pkg::MONTH_MAX;
  localparam int HR_TOP = cae_pkg::HOUR_MAX;
  localparam int MS_TOP = cae_pkg::MINSEC_MAX;
  localparam int FEB_LONG = cae_pkg::FEB_LEAP;
  localparam int FEB_SHORT = cae_pkg::FEB_PLAIN;
  localparam int MONTH_LONG = cae_pkg::DAYS_LONG;
  localparam int MONTH_SHORT = 30;
  localparam int FEBRUARY = 2;
  localparam int TIME_FIELDS = 6;
  localparam int ALARM_FIELDS = 3;

  // One request: key code plus the time read from the clock chip.
  typedef struct packed {
    logic [2:0]     key;
    cae_pkg::held_t rtc;
  } panel_request_t;

  // One result, in the order of the result ports.
  typedef struct packed {
    logic [1:0]      mode;
    cae_pkg::held_t  held;
    cae_pkg::alarm_t alarm;
    logic            ring;
    logic            write_time;
  } panel_result_t;

  // Predicts the panel state pass by pass and checks results in order.
  class panel_scoreboard;
    logic [1:0] cur_mode;
    int unsigned fsel;
    bit ring_armed;
    int held[TIME_FIELDS];
    int alarm_set[ALARM_FIELDS];
    panel_result_t expected_panels[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      cur_mode = cae_pkg::MODE_SHOW;
      fsel = 0;
      ring_armed = 1'b1;
      held = '{0, 1, 1, 0, 0, 0};
      alarm_set = '{0, 0, 0};
      mismatches = 0;
      results_seen = 0;
    endfunction

    // Days in a month; a month outside the calendar counts as a long one.
    function int month_limit(int yr, int mo);
      if (mo == FEBRUARY) return (yr % 4 == 0) ? FEB_LONG : FEB_SHORT;
      case (mo)
        4, 6, 9, 11: return MONTH_SHORT;
        default: return MONTH_LONG;
      endcase
    endfunction

    function void reload_from(cae_pkg::held_t rtc);
      held[cae_pkg::FLD_YEAR] = rtc.year;
      held[cae_pkg::FLD_MONTH] = rtc.month;
      held[cae_pkg::FLD_DAY] = rtc.day;
      held[cae_pkg::FLD_HOUR] = rtc.hour;
      held[cae_pkg::FLD_MINUTE] = rtc.minute;
      held[cae_pkg::FLD_SECOND] = rtc.second;
    endfunction

    // Time-set edits; every field is range checked after a step.
    function void edit_held(logic [2:0] k);
      int mx;
      if (k == cae_pkg::KEY_NEXT) begin
        fsel = (fsel + 1) % TIME_FIELDS;
        return;
      end
      if (k == cae_pkg::KEY_INC) begin
        if (fsel < TIME_FIELDS) held[fsel] += 1;
        if (held[cae_pkg::FLD_YEAR] > YR_TOP) held[cae_pkg::FLD_YEAR] = 0;
        if (held[cae_pkg::FLD_MONTH] > MO_TOP) held[cae_pkg::FLD_MONTH] = 1;
        mx = month_limit(held[cae_pkg::FLD_YEAR], held[cae_pkg::FLD_MONTH]);
        if (held[cae_pkg::FLD_DAY] > mx) held[cae_pkg::FLD_DAY] = 1;
        if (held[cae_pkg::FLD_HOUR] > HR_TOP) held[cae_pkg::FLD_HOUR] = 0;
        if (held[cae_pkg::FLD_MINUTE] > MS_TOP) held[cae_pkg::FLD_MINUTE] = 0;
        if (held[cae_pkg::FLD_SECOND] > MS_TOP) held[cae_pkg::FLD_SECOND] = 0;
      end else if (k == cae_pkg::KEY_DEC) begin
        if (fsel < TIME_FIELDS) held[fsel] -= 1;
        if (held[cae_pkg::FLD_YEAR] < 0) held[cae_pkg::FLD_YEAR] = YR_TOP;
        if (held[cae_pkg::FLD_MONTH] < 1) held[cae_pkg::FLD_MONTH] = MO_TOP;
        mx = month_limit(held[cae_pkg::FLD_YEAR], held[cae_pkg::FLD_MONTH]);
        if (held[cae_pkg::FLD_DAY] < 1) held[cae_pkg::FLD_DAY] = mx;
        if (held[cae_pkg::FLD_DAY] > mx) held[cae_pkg::FLD_DAY] = mx;
        if (held[cae_pkg::FLD_HOUR] < 0) held[cae_pkg::FLD_HOUR] = HR_TOP;
        if (held[cae_pkg::FLD_MINUTE] < 0) held[cae_pkg::FLD_MINUTE] = MS_TOP;
        if (held[cae_pkg::FLD_SECOND] < 0) held[cae_pkg::FLD_SECOND] = MS_TOP;
      end
    endfunction

    // Alarm-set edits wrap in both directions.
    function void edit_alarm(logic [2:0] k);
      if (k == cae_pkg::KEY_NEXT) begin
        fsel = (fsel + 1) % ALARM_FIELDS;
        return;
      end
      if (fsel >= ALARM_FIELDS) return;
      if (k == cae_pkg::KEY_INC) begin
        alarm_set[fsel] += 1;
        if (alarm_set[cae_pkg::ALM_HOUR] > HR_TOP) alarm_set[cae_pkg::ALM_HOUR] = 0;
        if (alarm_set[cae_pkg::ALM_MINUTE] > MS_TOP) alarm_set[cae_pkg::ALM_MINUTE] = 0;
        if (alarm_set[cae_pkg::ALM_SECOND] > MS_TOP) alarm_set[cae_pkg::ALM_SECOND] = 0;
      end else if (k == cae_pkg::KEY_DEC) begin
        alarm_set[fsel] -= 1;
        if (alarm_set[cae_pkg::ALM_HOUR] < 0) alarm_set[cae_pkg::ALM_HOUR] = HR_TOP;
        if (alarm_set[cae_pkg::ALM_MINUTE] < 0) alarm_set[cae_pkg::ALM_MINUTE] = MS_TOP;
        if (alarm_set[cae_pkg::ALM_SECOND] < 0) alarm_set[cae_pkg::ALM_SECOND] = MS_TOP;
      end
    endfunction

    // Advances the panel by one accepted request and queues its result.
    function void note_request(panel_request_t r);
      panel_result_t e;
      e.ring = ring_armed && held[cae_pkg::FLD_HOUR] == alarm_set[cae_pkg::ALM_HOUR] &&
               held[cae_pkg::FLD_MINUTE] == alarm_set[cae_pkg::ALM_MINUTE] &&
               held[cae_pkg::FLD_SECOND] == alarm_set[cae_pkg::ALM_SECOND];
      e.write_time = 1'b0;
      if (r.key == cae_pkg::KEY_MODE) begin
        case (cur_mode)
          cae_pkg::MODE_SHOW: begin
            cur_mode = cae_pkg::MODE_TIME;
            ring_armed = 1'b0;
          end
          cae_pkg::MODE_TIME: begin
            cur_mode = cae_pkg::MODE_ALARM;
            e.write_time = 1'b1;
            fsel = 0;
          end
          cae_pkg::MODE_ALARM: begin
            cur_mode = cae_pkg::MODE_SHOW;
            fsel = 0;
            ring_armed = 1'b1;
          end
          default: ;
        endcase
      end
      case (cur_mode)
        cae_pkg::MODE_SHOW: reload_from(r.rtc);
        cae_pkg::MODE_TIME: edit_held(r.key);
        cae_pkg::MODE_ALARM: begin
          reload_from(r.rtc);
          edit_alarm(r.key);
        end
        default: ;
      endcase
      e.mode = cur_mode;
      e.held.year = 7'(held[cae_pkg::FLD_YEAR]);
      e.held.month = 4'(held[cae_pkg::FLD_MONTH]);
      e.held.day = 5'(held[cae_pkg::FLD_DAY]);
      e.held.hour = 5'(held[cae_pkg::FLD_HOUR]);
      e.held.minute = 6'(held[cae_pkg::FLD_MINUTE]);
      e.held.second = 6'(held[cae_pkg::FLD_SECOND]);
      e.alarm.hour = 5'(alarm_set[cae_pkg::ALM_HOUR]);
      e.alarm.minute = 6'(alarm_set[cae_pkg::ALM_MINUTE]);
      e.alarm.second = 6'(alarm_set[cae_pkg::ALM_SECOND]);
      expected_panels.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch on %s in result %0d: expected %0d, actual %0d",
                   name, results_seen, want, got);
      end
    endfunction

    function void check_result(panel_result_t got);
      panel_result_t want;
      results_seen++;
      if (expected_panels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d arrived with no request outstanding", results_seen);
        return;
      end
      want = expected_panels.pop_front();
      compare_field("ui_mode", want.mode, got.mode);
      compare_field("out_year", want.held.year, got.held.year);
      compare_field("out_month", want.held.month, got.held.month);
      compare_field("out_day", want.held.day, got.held.day);
      compare_field("out_hour", want.held.hour, got.held.hour);
      compare_field("out_minute", want.held.minute, got.held.minute);
      compare_field("out_second", want.held.second, got.held.second);
      compare_field("alarm_hour_out", want.alarm.hour, got.alarm.hour);
      compare_field("alarm_minute_out", want.alarm.minute, got.alarm.minute);
      compare_field("alarm_second_out", want.alarm.second, got.alarm.second);
      compare_field("ring", want.ring, got.ring);
      compare_field("write_time", want.write_time, got.write_time);
    endfunction

    function int pending();
      return expected_panels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] key = cae_pkg::KEY_NONE;
  logic [6:0] rtc_year = '0;
  logic [3:0] rtc_month = '0;
  logic [4:0] rtc_day = '0;
  logic [4:0] rtc_hour = '0;
  logic [5:0] rtc_minute = '0;
  logic [5:0] rtc_second = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] ui_mode;
  logic [6:0] out_year;
  logic [3:0] out_month;
  logic [4:0] out_day;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;
  logic [4:0] alarm_hour_out;
  logic [5:0] alarm_minute_out;
  logic [5:0] alarm_second_out;
  logic ring;
  logic write_time;

  bit steady = 1'b0;
  int passes_sent = 0;
  panel_scoreboard panel_check = new();
  panel_result_t seen_panel;

  clock_alarm_set_editor_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .key(key),
    .rtc_year(rtc_year),
    .rtc_month(rtc_month),
    .rtc_day(rtc_day),
    .rtc_hour(rtc_hour),
    .rtc_minute(rtc_minute),
    .rtc_second(rtc_second),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ui_mode(ui_mode),
    .out_year(out_year),
    .out_month(out_month),
    .out_day(out_day),
    .out_hour(out_hour),
    .out_minute(out_minute),
    .out_second(out_second),
    .alarm_hour_out(alarm_hour_out),
    .alarm_minute_out(alarm_minute_out),
    .alarm_second_out(alarm_second_out),
    .ring(ring),
    .write_time(write_time)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Receiver stalls at random, except during reset and the steady stretch.
  always @(posedge clk) begin
    if (rst || steady) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < IDLE_PCT);
  end

  assign seen_panel = {ui_mode, out_year, out_month, out_day, out_hour, out_minute,
                       out_second, alarm_hour_out, alarm_minute_out, alarm_second_out,
                       ring, write_time};

  // Every result taken by the receiver is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) panel_check.check_result(seen_panel);
  end

  function automatic cae_pkg::held_t rtc_of(int y, int mo, int d, int h, int mi, int s);
    cae_pkg::held_t t;
    t.year = 7'(y);
    t.month = 4'(mo);
    t.day = 5'(d);
    t.hour = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    return t;
  endfunction

  function automatic panel_request_t pass_of(logic [2:0] k, cae_pkg::held_t rtc);
    panel_request_t r;
    r.key = k;
    r.rtc = rtc;
    return r;
  endfunction

  // Clock chip time: mostly calendar values, some February days near the
  // month end, some with every bit random; optionally matching the alarm.
  function automatic cae_pkg::held_t rand_rtc(bit match_alarm);
    cae_pkg::held_t t;
    int unsigned p;
    p = $urandom_range(99);
    if (p < 20) begin
      t.year = 7'($urandom());
      t.month = 4'($urandom());
      t.day = 5'($urandom());
      t.hour = 5'($urandom());
      t.minute = 6'($urandom());
      t.second = 6'($urandom());
    end else begin
      t = rtc_of($urandom_range(YR_TOP), $urandom_range(MO_TOP, 1),
                 $urandom_range(MONTH_LONG, 1), $urandom_range(HR_TOP),
                 $urandom_range(MS_TOP), $urandom_range(MS_TOP));
      if (p < 40) begin
        if ($urandom_range(1) == 0) t.year = 7'(4 * $urandom_range(YR_TOP / 4));
        t.month = 4'(FEBRUARY);
        t.day = 5'($urandom_range(MONTH_LONG, FEB_SHORT - 1));
      end
    end
    if (match_alarm) begin
      t.hour = 5'(panel_check.alarm_set[cae_pkg::ALM_HOUR]);
      t.minute = 6'(panel_check.alarm_set[cae_pkg::ALM_MINUTE]);
      t.second = 6'(panel_check.alarm_set[cae_pkg::ALM_SECOND]);
    end
    return t;
  endfunction

  // Mostly field steps, now and then no key or a spare code.
  function automatic logic [2:0] pick_edit_key();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 30) return cae_pkg::KEY_NEXT;
    if (p < 60) return cae_pkg::KEY_INC;
    if (p < 90) return cae_pkg::KEY_DEC;
    if (p < 95) return cae_pkg::KEY_NONE;
    return 3'($urandom_range(KEY_SPARE_LAST, KEY_SPARE_FIRST));
  endfunction

  // Presents one request, idling at random first, and waits until it is taken.
  task automatic send_request(input panel_request_t r);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key <= r.key;
    rtc_year <= r.rtc.year;
    rtc_month <= r.rtc.month;
    rtc_day <= r.rtc.day;
    rtc_hour <= r.rtc.hour;
    rtc_minute <= r.rtc.minute;
    rtc_second <= r.rtc.second;
    do @(posedge clk); while (in_stall);
    panel_check.note_request(r);
    passes_sent++;
    steady <= (passes_sent >= STEADY_FROM && passes_sent < STEADY_TO);
  endtask

  // Holds off new requests until every predicted result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (panel_check.pending() != 0) @(posedge clk);
  endtask

  // A full trip round the modes with random edits and rtc content.
  task automatic run_edit_session();
    int n;
    logic [2:0] k;
    while (panel_check.cur_mode != cae_pkg::MODE_SHOW)
      send_request(pass_of(cae_pkg::KEY_MODE, rand_rtc(1'b0)));
    n = $urandom_range(4, 1);
    repeat (n) begin
      k = 3'($urandom_range(7));
      if (k == cae_pkg::KEY_MODE) k = cae_pkg::KEY_NONE;
      send_request(pass_of(k, rand_rtc($urandom_range(4) == 0)));
    end
    send_request(pass_of(cae_pkg::KEY_MODE, rand_rtc(1'b0)));
    n = $urandom_range(20);
    repeat (n) send_request(pass_of(pick_edit_key(), rand_rtc(1'b0)));
    send_request(pass_of(cae_pkg::KEY_MODE, rand_rtc(1'b0)));
    n = $urandom_range(12);
    repeat (n) send_request(pass_of(pick_edit_key(), rand_rtc(1'b0)));
    send_request(pass_of(cae_pkg::KEY_MODE, rand_rtc($urandom_range(1) == 0)));
    send_request(pass_of(cae_pkg::KEY_NONE, rand_rtc(1'b0)));
  endtask

  // Short burst of arbitrary keys, which may leave the panel in any mode.
  task automatic run_noise_burst();
    int n;
    n = $urandom_range(8, 1);
    repeat (n) send_request(pass_of(3'($urandom_range(7)), rand_rtc($urandom_range(9) == 0)));
  endtask

  initial begin
    cae_pkg::held_t blank;
    bit drained_mid;
    blank = rtc_of(0, 0, 0, 0, 0, 0);
    drained_mid = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state rings at once; then all-zero and all-ones clock inputs.
    send_request(pass_of(cae_pkg::KEY_NONE, blank));
    send_request(pass_of(KEY_SPARE_LAST, rtc_of(127, 15, 31, 31, 63, 63)));
    send_request(pass_of(cae_pkg::KEY_NONE, rtc_of(0, 0, 31, 0, 0, 0)));
    // Time set with month zero: increment keeps it, decrement wraps it.
    send_request(pass_of(cae_pkg::KEY_MODE, rtc_of(127, 15, 31, 31, 63, 63)));
    send_request(pass_of(cae_pkg::KEY_INC, blank));
    send_request(pass_of(cae_pkg::KEY_DEC, blank));
    send_request(pass_of(cae_pkg::KEY_DEC, blank));
    // Month past December, then February in a plain year drops day 31 to 1.
    send_request(pass_of(cae_pkg::KEY_NEXT, blank));
    send_request(pass_of(cae_pkg::KEY_INC, blank));
    send_request(pass_of(cae_pkg::KEY_INC, blank));
    // Day below one takes the month maximum; hour below zero wraps.
    send_request(pass_of(cae_pkg::KEY_NEXT, blank));
    send_request(pass_of(cae_pkg::KEY_DEC, blank));
    send_request(pass_of(cae_pkg::KEY_NEXT, blank));
    send_request(pass_of(cae_pkg::KEY_DEC, blank));
    send_request(pass_of(cae_pkg::KEY_NEXT, blank));
    send_request(pass_of(cae_pkg::KEY_NEXT, blank));
    send_request(pass_of(cae_pkg::KEY_INC, blank));
    send_request(pass_of(cae_pkg::KEY_NEXT, blank));
    // Leaving time set raises the write strobe; alarm fields wrap both ways.
    send_request(pass_of(cae_pkg::KEY_MODE, rtc_of(96, 2, 29, 23, 59, 59)));
    send_request(pass_of(cae_pkg::KEY_DEC, blank));
    send_request(pass_of(cae_pkg::KEY_NEXT, blank));
    send_request(pass_of(cae_pkg::KEY_DEC, blank));
    send_request(pass_of(cae_pkg::KEY_NEXT, blank));
    send_request(pass_of(cae_pkg::KEY_NEXT, blank));
    send_request(pass_of(cae_pkg::KEY_INC, blank));
    send_request(pass_of(KEY_SPARE_FIRST, blank));
    // Back to show with the alarm time loaded, so the next pass rings.
    send_request(pass_of(cae_pkg::KEY_MODE, rtc_of(0, 1, 1, 0, 59, 0)));
    send_request(pass_of(cae_pkg::KEY_NONE, blank));
    wait_for_results();

    // Random part: mostly mode trips with edits, the rest arbitrary keys.
    while (passes_sent < PASS_TOTAL) begin
      if (!drained_mid && passes_sent >= MID_DRAIN) begin
        wait_for_results();
        drained_mid = 1'b1;
      end
      if ($urandom_range(99) < 80) run_edit_session();
      else run_noise_burst();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (panel_check.mismatches == 0 && panel_check.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard limit on the run in case results stop coming.
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
